FILE: rtl/eepr_pkg.sv
// ----------------------------------------------------------------------------
// eepr_pkg
// Shared types and constants for the serial EEPROM page sequencer.
// ----------------------------------------------------------------------------
package eepr_pkg;

    localparam int PAGE_BYTES_DEF = 64;
    localparam int PAGE_COUNT_DEF = 512;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] DEV_RD_BIT = 8'h01;
    localparam logic [7:0] DEV_WR_MASK = 8'hFE;
    localparam logic [7:0] DEV_ADDR_RST = 8'd160;

    typedef enum logic [2:0] {
        SYM_START   = 3'd0,
        SYM_SEND    = 3'd1,
        SYM_RX_ACK  = 3'd2,
        SYM_RX_NACK = 3'd3,
        SYM_STOP    = 3'd4,
        SYM_WAIT    = 3'd5,
        SYM_NONE    = 3'd6
    } sym_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NACK  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Symbol slots in bus order; one descriptor mask bit per slot.
    typedef enum logic [3:0] {
        SLOT_NONE   = 4'd0,
        SLOT_START  = 4'd1,
        SLOT_DEV_W  = 4'd2,
        SLOT_ADDR_H = 4'd3,
        SLOT_ADDR_L = 4'd4,
        SLOT_RSTART = 4'd5,
        SLOT_DEV_R  = 4'd6,
        SLOT_DATA   = 4'd7,
        SLOT_STOP   = 4'd8,
        SLOT_WAIT   = 4'd9
    } slot_t;

    localparam int SLOT_N = 10;

    typedef struct packed {
        logic [SLOT_N-1:0] mask;
        status_t           status;
        logic              is_read;
        logic              is_last;
        logic [15:0]       addr;
        logic [7:0]        payload;
    } desc_t;

endpackage

FILE: rtl/eepr_if.sv
// ----------------------------------------------------------------------------
// eepr_req_if / eepr_rsp_if
// Valid/ready channels for request items and bus symbol items.
// ----------------------------------------------------------------------------
interface eepr_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] mem_addr;
    logic [7:0]  data_byte;
    logic [7:0]  rx_byte;
    logic        device_ack;
    logic        first_byte;
    logic        last_byte;

    modport source (
        output valid, req_type, mem_addr, data_byte, rx_byte, device_ack,
               first_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, mem_addr, data_byte, rx_byte, device_ack,
               first_byte, last_byte,
        output ready
    );
endinterface

interface eepr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_symbol;
    logic [7:0] symbol_byte;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic       last_symbol;

    modport source (
        output valid, bus_symbol, symbol_byte, read_byte, status, last_symbol,
        input  ready
    );
    modport sink (
        input  valid, bus_symbol, symbol_byte, read_byte, status, last_symbol,
        output ready
    );
endinterface

FILE: rtl/eepr_front.sv
// ----------------------------------------------------------------------------
// eepr_front
// Accepts request items, tracks address/page/abort state and turns each item
// into a descriptor listing the bus symbols it needs.
// ----------------------------------------------------------------------------
module eepr_front #(
    parameter int PAGE_BYTES = eepr_pkg::PAGE_BYTES_DEF,
    parameter int PAGE_COUNT = eepr_pkg::PAGE_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    eepr_req_if.sink        req,
    output eepr_pkg::desc_t desc,
    output logic            desc_valid,
    input  logic            desc_full
);

    localparam int          OFF_W    = $clog2(PAGE_BYTES);
    localparam logic [18:0] MEM_SIZE = 19'(PAGE_BYTES * PAGE_COUNT);
    localparam logic [13:0] RECIP    = 14'((1 << 16) / PAGE_BYTES);

    // hold stage
    logic        hold_valid_reg;
    logic        h_req_reg;
    logic [15:0] h_addr_reg;
    logic [7:0]  h_data_reg;
    logic [7:0]  h_rx_reg;
    logic        h_ack_reg;
    logic        h_first_reg;
    logic        h_last_reg;
    logic [13:0] h_quot_reg;

    // burst state
    logic [15:0]      cur_addr_reg, cur_addr_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic             page_open_reg, page_open_next;
    logic             aborted_reg, aborted_next;

    logic        push;
    logic [29:0] recip_prod;
    logic [22:0] quot_times_pb;
    logic [22:0] rem_wide;
    logic [9:0]  rem_raw;
    logic [OFF_W-1:0] rem_off;

    logic             first_oor;
    logic [15:0]      cur_in;
    logic [OFF_W-1:0] off_in;
    logic             page_in, ab_in, page_end;
    logic [15:0]      addr_inc;
    logic [OFF_W-1:0] off_inc;

    assign push       = hold_valid_reg && !desc_full;
    assign req.ready  = !hold_valid_reg || push;
    assign desc_valid = hold_valid_reg;

    // quotient estimate of mem_addr / PAGE_BYTES, low by at most one
    assign recip_prod = 30'(req.mem_addr) * 30'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            h_req_reg   <= req.req_type;
            h_addr_reg  <= req.mem_addr;
            h_data_reg  <= req.data_byte;
            h_rx_reg    <= req.rx_byte;
            h_ack_reg   <= req.device_ack;
            h_first_reg <= req.first_byte;
            h_last_reg  <= req.last_byte;
            h_quot_reg  <= recip_prod[29:16];
        end
    end

    // page offset of the start address
    always_comb
    begin
        quot_times_pb = 23'(h_quot_reg) * 23'(PAGE_BYTES);
        rem_wide      = 23'(h_addr_reg) - quot_times_pb;
        rem_raw       = rem_wide[9:0];
        if (rem_raw >= 10'(PAGE_BYTES))
        begin
            rem_raw = rem_raw - 10'(PAGE_BYTES);
        end
        rem_off = OFF_W'(rem_raw);
    end

    always_comb
    begin
        first_oor = h_first_reg && ({3'b000, h_addr_reg} >= MEM_SIZE);
        cur_in    = h_first_reg ? h_addr_reg : cur_addr_reg;
        off_in    = h_first_reg ? rem_off : offset_reg;
        page_in   = h_first_reg ? 1'b0 : page_open_reg;
        ab_in     = h_first_reg ? 1'b0 : aborted_reg;
        page_end  = (cur_in == 16'hFFFF) || (off_in == OFF_W'(PAGE_BYTES - 1));
        addr_inc  = cur_in + 16'd1;
        off_inc   = page_end ? '0 : off_in + OFF_W'(1);

        desc.mask    = '0;
        desc.status  = eepr_pkg::ST_OK;
        desc.is_read = h_req_reg;
        desc.is_last = h_last_reg;
        desc.addr    = cur_in;
        desc.payload = h_req_reg ? h_rx_reg : h_data_reg;

        cur_addr_next  = cur_in;
        offset_next    = off_in;
        page_open_next = page_in;
        aborted_next   = ab_in;

        if (first_oor)
        begin
            desc.mask[eepr_pkg::SLOT_NONE] = 1'b1;
            desc.status    = eepr_pkg::ST_RANGE;
            cur_addr_next  = cur_addr_reg;
            offset_next    = offset_reg;
            page_open_next = 1'b0;
            aborted_next   = 1'b1;
        end
        else if (ab_in)
        begin
            desc.mask[eepr_pkg::SLOT_NONE] = 1'b1;
        end
        else
        begin
            if (!page_in)
            begin
                desc.mask[eepr_pkg::SLOT_START]  = 1'b1;
                desc.mask[eepr_pkg::SLOT_DEV_W]  = 1'b1;
                desc.mask[eepr_pkg::SLOT_ADDR_H] = 1'b1;
                desc.mask[eepr_pkg::SLOT_ADDR_L] = 1'b1;
                desc.mask[eepr_pkg::SLOT_RSTART] = h_req_reg;
                desc.mask[eepr_pkg::SLOT_DEV_R]  = h_req_reg;
                page_open_next = 1'b1;
            end
            desc.mask[eepr_pkg::SLOT_DATA] = 1'b1;
            if (h_req_reg)
            begin
                cur_addr_next = addr_inc;
                offset_next   = off_inc;
                if (h_last_reg)
                begin
                    desc.mask[eepr_pkg::SLOT_STOP] = 1'b1;
                    page_open_next = 1'b0;
                end
            end
            else if (!h_ack_reg)
            begin
                desc.mask[eepr_pkg::SLOT_STOP] = 1'b1;
                desc.status    = eepr_pkg::ST_NACK;
                aborted_next   = 1'b1;
                page_open_next = 1'b0;
            end
            else
            begin
                cur_addr_next = addr_inc;
                offset_next   = off_inc;
                // last byte or page boundary reached: close the page write
                if (h_last_reg || page_end)
                begin
                    desc.mask[eepr_pkg::SLOT_STOP] = 1'b1;
                    desc.mask[eepr_pkg::SLOT_WAIT] = 1'b1;
                    page_open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_addr_reg  <= '0;
            offset_reg    <= '0;
            page_open_reg <= 1'b0;
            aborted_reg   <= 1'b0;
        end
        else if (push)
        begin
            cur_addr_reg  <= cur_addr_next;
            offset_reg    <= offset_next;
            page_open_reg <= page_open_next;
            aborted_reg   <= aborted_next;
        end
    end

endmodule

FILE: rtl/eepr_queue.sv
// ----------------------------------------------------------------------------
// eepr_queue
// Small descriptor FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module eepr_queue #(
    parameter int DEPTH = eepr_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  eepr_pkg::desc_t push_data,
    output logic            full,
    input  logic            pop,
    output eepr_pkg::desc_t pop_data,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    eepr_pkg::desc_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/eepr_back.sv
// ----------------------------------------------------------------------------
// eepr_back
// Walks a descriptor's slot mask and emits one bus symbol item per cycle,
// unless rsp.ready or an empty queue holds it, via a registered output stage.
// ----------------------------------------------------------------------------
module eepr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  eepr_pkg::desc_t q_data,
    input  logic            q_empty,
    output logic            q_pop,
    input  logic [7:0]      dev_addr,
    eepr_rsp_if.source      rsp
);

    eepr_pkg::desc_t               act_reg;
    logic [eepr_pkg::SLOT_N-1:0]   rem_reg;
    logic [eepr_pkg::SLOT_N-1:0]   low_bit, rem_after;
    eepr_pkg::slot_t               slot;
    logic                          have, emit_ok, emit;

    logic       out_valid_reg;
    logic [2:0] out_sym_reg;
    logic [7:0] out_sbyte_reg;
    logic [7:0] out_rbyte_reg;
    logic [1:0] out_status_reg;
    logic       out_last_reg;

    eepr_pkg::sym_t    sym;
    logic [7:0]        sbyte, rbyte;
    eepr_pkg::status_t st;

    assign have      = rem_reg != '0;
    assign low_bit   = rem_reg & (-rem_reg);
    assign rem_after = rem_reg & ~low_bit;
    assign emit_ok   = !out_valid_reg || rsp.ready;
    assign emit      = emit_ok && have;
    assign q_pop     = !q_empty && (!have || (emit && rem_after == '0));

    always_comb
    begin
        slot = eepr_pkg::SLOT_NONE;
        for (int i = 0; i < eepr_pkg::SLOT_N; i++)
        begin
            if (low_bit[i])
            begin
                slot = eepr_pkg::slot_t'(4'(i));
            end
        end
    end

    always_comb
    begin
        sym   = eepr_pkg::SYM_NONE;
        sbyte = 8'h00;
        rbyte = 8'h00;
        st    = eepr_pkg::ST_OK;
        unique case (slot) inside
            eepr_pkg::SLOT_NONE:
            begin
                st = act_reg.status;
            end
            eepr_pkg::SLOT_START, eepr_pkg::SLOT_RSTART:
            begin
                sym = eepr_pkg::SYM_START;
            end
            eepr_pkg::SLOT_DEV_W:
            begin
                sym   = eepr_pkg::SYM_SEND;
                sbyte = dev_addr & eepr_pkg::DEV_WR_MASK;
            end
            eepr_pkg::SLOT_DEV_R:
            begin
                sym   = eepr_pkg::SYM_SEND;
                sbyte = dev_addr | eepr_pkg::DEV_RD_BIT;
            end
            eepr_pkg::SLOT_ADDR_H:
            begin
                sym   = eepr_pkg::SYM_SEND;
                sbyte = act_reg.addr[15:8];
            end
            eepr_pkg::SLOT_ADDR_L:
            begin
                sym   = eepr_pkg::SYM_SEND;
                sbyte = act_reg.addr[7:0];
            end
            eepr_pkg::SLOT_DATA:
            begin
                if (act_reg.is_read)
                begin
                    sym   = act_reg.is_last ? eepr_pkg::SYM_RX_NACK : eepr_pkg::SYM_RX_ACK;
                    rbyte = act_reg.payload;
                end
                else
                begin
                    sym   = eepr_pkg::SYM_SEND;
                    sbyte = act_reg.payload;
                end
            end
            eepr_pkg::SLOT_STOP:
            begin
                sym = eepr_pkg::SYM_STOP;
                st  = act_reg.status;
            end
            eepr_pkg::SLOT_WAIT:
            begin
                sym = eepr_pkg::SYM_WAIT;
            end
            default:
            begin
                sym = eepr_pkg::SYM_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (q_pop)
        begin
            rem_reg <= q_data.mask;
        end
        else if (emit)
        begin
            rem_reg <= rem_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            act_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_sym_reg    <= sym;
            out_sbyte_reg  <= sbyte;
            out_rbyte_reg  <= rbyte;
            out_status_reg <= st;
            out_last_reg   <= rem_after == '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.bus_symbol  = out_sym_reg;
    assign rsp.symbol_byte = out_sbyte_reg;
    assign rsp.read_byte   = out_rbyte_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.last_symbol = out_last_reg;

endmodule

FILE: rtl/i2c_eeprom_page_sequencer_unit.sv
// An item's first bus symbol passes the hold stage, queue, descriptor load and
// output register after acceptance; 1 to 8 symbols per item. Throughput: one
// symbol per cycle from the back end unless rsp.ready stalls it; an item that
// reaches a drained queue is loaded before its symbols start. The front takes
// an item per cycle unless the queue is full.
// Reset clears address, page and abort state and sets the device address to 160.
// ----------------------------------------------------------------------------
// i2c_eeprom_page_sequencer_unit
// Serial EEPROM page write/read bus-symbol sequencer: front classifier,
// descriptor queue and symbol emitter.
// ----------------------------------------------------------------------------
module i2c_eeprom_page_sequencer_unit #(
    parameter int PAGE_BYTES = eepr_pkg::PAGE_BYTES_DEF,
    parameter int PAGE_COUNT = eepr_pkg::PAGE_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    eepr_req_if.sink   req,
    eepr_rsp_if.source rsp,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic [7:0]      dev_addr_reg;
    eepr_pkg::desc_t front_desc, q_data;
    logic            front_valid, q_full, q_empty, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= eepr_pkg::DEV_ADDR_RST;
        end
        else if (cfg_we)
        begin
            dev_addr_reg <= cfg_wdata;
        end
    end

    eepr_front #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .desc       (front_desc),
        .desc_valid (front_valid),
        .desc_full  (q_full)
    );

    eepr_queue #(
        .DEPTH (eepr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    eepr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_data),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .dev_addr (dev_addr_reg),
        .rsp      (rsp)
    );

endmodule
